// File: hw/rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

  // Operation codes carried in the func field
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  // Status codes returned with every result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam int KeyW   = 32;
  localparam int CountW = 5;

  typedef struct packed {
    logic [2:0]             func;
    logic signed [KeyW-1:0] key_in;
  } deq_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [KeyW-1:0] key_out;
    logic [CountW-1:0]      count;
  } deq_rsp_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic shift_in;    // push front: every entry moves one cell toward the back
    logic shift_out;   // pop front: every entry moves one cell toward the front
    logic write_tail;  // push back: the cell just past the last entry takes the key
  } deq_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/deq_cell.sv
`default_nettype none

module deq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire                                     clk,
  input  wire deq_pkg::deq_ctrl_t                 ctrl,
  input  wire logic [CNT_W-1:0]                   count,
  input  wire logic signed [deq_pkg::KeyW-1:0]    key,
  input  wire logic signed [deq_pkg::KeyW-1:0]    left,
  input  wire logic signed [deq_pkg::KeyW-1:0]    right,
  output logic signed [deq_pkg::KeyW-1:0]         data,
  output logic signed [deq_pkg::KeyW-1:0]         tail
);

  localparam logic [CNT_W-1:0] MyIdx   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] LastIdx = CNT_W'(IDX + 1);

  // Entry register: shift with the neighbors or take the key at the tail
  always_ff @(posedge clk) begin
    if (ctrl.shift_in) begin
      data <= left;
    end else if (ctrl.shift_out) begin
      data <= right;
    end else if (ctrl.write_tail && (count == MyIdx)) begin
      data <= key;
    end
  end

  // Offer the entry for a back pop only when this cell holds the last entry
  assign tail = (count == LastIdx) ? data : '0;

endmodule

`default_nettype wire

// File: hw/rtl/double_ended_queue_unit.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit keys.
// Request channel (req_valid/req_ready/req): func selects push front, push
// back, pop front, pop back or clear; key_in is used by pushes only.
// Response channel (rsp_valid/rsp_ready/rsp): one response per request with
// status, popped key (zero unless a pop succeeds) and the count afterward.
// Entries live in a row of DEPTH cells with the front entry in cell 0; a
// front push or pop shifts the whole row by one cell, a back push writes
// the cell at the count, a back pop selects the cell of the last entry.
// The response is registered, valid in the cycle after request transfer.
// One request is taken per cycle, limited by the single response register:
// a new request is accepted whenever that register is empty or drains in the
// same cycle. When the receiver stalls, the response holds and req_ready
// drops until it is taken. Reset empties the queue and drops rsp_valid;
// stored keys are not cleared, as they are unreachable when empty.
// A push into a full queue returns status full and changes nothing.
module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       req_valid,
  output logic                      req_ready,
  input  wire deq_pkg::deq_req_t    req,
  output logic                      rsp_valid,
  input  wire                       rsp_ready,
  output deq_pkg::deq_rsp_t         rsp
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  logic                             accept;
  logic [CntW-1:0]                  cnt;
  logic [CntW-1:0]                  cnt_next;
  logic [1:0]                       status_next;
  logic signed [deq_pkg::KeyW-1:0]  key_next;
  logic signed [deq_pkg::KeyW-1:0]  back_key;
  logic [CntW+deq_pkg::CountW-1:0]  cnt_ext;
  deq_pkg::deq_ctrl_t               ctrl;
  logic signed [deq_pkg::KeyW-1:0]  cell_data [DEPTH];
  logic signed [deq_pkg::KeyW-1:0]  tail_data [DEPTH];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  // Row of cells; the ends feed the key in and hold their own value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::KeyW-1:0] left;
    logic signed [deq_pkg::KeyW-1:0] right;
    if (i == 0) begin : g_head
      assign left = req.key_in;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right = cell_data[i];
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    deq_cell #(
      .IDX  (i),
      .CNT_W(CntW)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .count(cnt),
      .key  (req.key_in),
      .left (left),
      .right(right),
      .data (cell_data[i]),
      .tail (tail_data[i])
    );
  end

  // Gather the last entry; only one cell drives a nonzero value
  always_comb begin
    back_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_key = back_key | tail_data[i];
    end
  end

  // Decode the request
  always_comb begin
    ctrl        = '0;
    cnt_next    = cnt;
    status_next = deq_pkg::ST_OK;
    key_next    = '0;
    case (req.func)
      deq_pkg::OP_PUSH_FRONT: begin
        if (cnt == Full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          ctrl.shift_in = accept;
          cnt_next      = cnt + CntW'(1);
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (cnt == Full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          ctrl.write_tail = accept;
          cnt_next        = cnt + CntW'(1);
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (cnt == '0) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          ctrl.shift_out = accept;
          key_next       = cell_data[0];
          cnt_next       = cnt - CntW'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (cnt == '0) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          key_next = back_key;
          cnt_next = cnt - CntW'(1);
        end
      end
      deq_pkg::OP_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
        status_next = deq_pkg::ST_BAD;
      end
    endcase
  end

  assign cnt_ext = {{deq_pkg::CountW{1'b0}}, cnt_next};

  // Count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status  <= status_next;
      rsp.key_out <= key_next;
      rsp.count   <= cnt_ext[deq_pkg::CountW-1:0];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= Full)
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (req.func == deq_pkg::OP_PUSH_BACK || req.func == deq_pkg::OP_PUSH_FRONT)
      && cnt != Full |=> cnt == $past(cnt) + CntW'(1))
    else $error("successful push did not grow the count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == deq_pkg::ST_FULL |-> cnt == Full)
    else $error("full status while queue not full");

  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != deq_pkg::ST_OK |-> rsp.key_out == '0)
    else $error("nonzero key on failed request");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request stalled with empty response register");

endmodule

`default_nettype wire

// File: verif/tb_double_ended_queue_unit.sv
module tb_double_ended_queue_unit;

  localparam int CLK_PERIOD     = 12;
  localparam int DEPTH          = 16;
  localparam int ITEM_TARGET    = 800;
  localparam int CALM_ITEMS     = 120;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 250000;
  localparam int PRINT_LIMIT    = 50;

  // func codes with no defined operation
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic              hold;  // wait for all responses before sending this one
    deq_pkg::deq_req_t req;
  } pending_req_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  deq_pkg::deq_req_t req       = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  deq_pkg::deq_rsp_t rsp;

  pending_req_t      request_q[$];
  deq_pkg::deq_rsp_t expected_rsp_q[$];

  int   mismatches  = 0;
  int   sent_total  = 0;
  int   taken_total = 0;
  int   gap_left    = 0;
  int   stall_left  = 0;
  logic calm        = 1'b0;

  // Shadow deque state
  logic signed [31:0] key_ring [DEPTH];
  logic [3:0]         front_slot = '0;
  logic [4:0]         fill_level = '0;

  double_ended_queue_unit #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Applies one request to the shadow deque and returns its response
  function automatic deq_pkg::deq_rsp_t predict_deque_response(deq_pkg::deq_req_t r);
    deq_pkg::deq_rsp_t res;
    logic [3:0]        slot;
    res        = '0;
    res.status = deq_pkg::ST_OK;
    case (r.func)
      deq_pkg::OP_PUSH_FRONT: begin
        if (fill_level == DEPTH) begin
          res.status = deq_pkg::ST_FULL;
        end else begin
          front_slot           = front_slot - 1'b1;
          key_ring[front_slot] = r.key_in;
          fill_level           = fill_level + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (fill_level == DEPTH) begin
          res.status = deq_pkg::ST_FULL;
        end else begin
          slot           = front_slot + fill_level[3:0];
          key_ring[slot] = r.key_in;
          fill_level     = fill_level + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (fill_level == 0) begin
          res.status = deq_pkg::ST_EMPTY;
        end else begin
          res.key_out = key_ring[front_slot];
          front_slot  = front_slot + 1'b1;
          fill_level  = fill_level - 1'b1;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (fill_level == 0) begin
          res.status = deq_pkg::ST_EMPTY;
        end else begin
          slot        = front_slot + fill_level[3:0] - 1'b1;
          res.key_out = key_ring[slot];
          fill_level  = fill_level - 1'b1;
        end
      end
      deq_pkg::OP_CLEAR: begin
        front_slot = '0;
        fill_level = '0;
      end
      default: res.status = deq_pkg::ST_BAD;
    endcase
    res.count = fill_level;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
  endtask

  function automatic void add_request(logic [2:0] f, logic [31:0] k);
    pending_req_t p;
    p.req.func   = f;
    p.req.key_in = k;
    // a few points in the run where the sender lets the block drain first
    p.hold       = (request_q.size() % 275) == 274;
    request_q.push_back(p);
  endfunction

  // Mostly random keys, with the extremes mixed in
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random push code, or random pop code
  function automatic logic [2:0] pick_push();
    return 3'($urandom_range(deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK));
  endfunction

  function automatic logic [2:0] pick_pop();
    return 3'($urandom_range(deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK));
  endfunction

  // Driver: sends pending requests with random gap bursts
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) sent_total++;
      if (rsp_valid && rsp_ready) taken_total++;
      calm <= request_q.size() < CALM_ITEMS;
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (request_q.size() == 0 ||
                     (request_q[0].hold && sent_total != taken_total)) begin
          req_valid <= 1'b0;
        end else begin
          req       <= request_q[0].req;
          req_valid <= 1'b1;
          request_q.pop_front();
          if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 10);
        end
      end
    end
  end

  // Monitor: checks each response transfer, predicts on each request transfer
  always @(posedge clk) begin : response_check
    deq_pkg::deq_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response with no request pending", '0, 32'(rsp.status));
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(rsp.status));
          if (rsp.key_out !== want.key_out)
            report_mismatch("key_out", want.key_out, rsp.key_out);
          if (rsp.count !== want.count)
            report_mismatch("count", 32'(want.count), 32'(rsp.count));
        end
      end
      if (req_valid && req_ready) expected_rsp_q.push_back(predict_deque_response(req));
      // receiver stall bursts
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int len;
    // directed: empty pops, extreme keys, spare codes, clear
    add_request(deq_pkg::OP_POP_FRONT, pick_key());
    add_request(deq_pkg::OP_POP_BACK, pick_key());
    add_request(deq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
    add_request(deq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    add_request(deq_pkg::OP_PUSH_FRONT, 32'hffff_ffff);
    add_request(deq_pkg::OP_PUSH_BACK, 32'h0000_0000);
    add_request(OP_SPARE_FIRST, 32'h5555_5555);
    add_request(OP_SPARE_FIRST + 3'd1, 32'haaaa_aaaa);
    add_request(OP_SPARE_LAST, '1);
    add_request(deq_pkg::OP_POP_BACK, '0);
    add_request(deq_pkg::OP_POP_FRONT, '0);
    add_request(deq_pkg::OP_CLEAR, '1);
    add_request(deq_pkg::OP_POP_BACK, '0);
    add_request(deq_pkg::OP_PUSH_BACK, 32'h1234_5678);
    add_request(deq_pkg::OP_POP_FRONT, '0);
    // fill past full so the overflow refusal shows up early
    for (int i = 0; i < DEPTH + 2; i++)
      add_request(pick_push(), pick_key());

    // random segments: fill runs, drain runs, mixed runs, clears, spare codes
    while (request_q.size() < ITEM_TARGET) begin
      len = $urandom_range(5, 24);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (int i = 0; i < len; i++)
            if ($urandom_range(0, 4) != 0)
              add_request(pick_push(), pick_key());
            else
              add_request(pick_pop(), pick_key());
        end
        3, 4, 5: begin
          for (int i = 0; i < len; i++)
            if ($urandom_range(0, 4) != 0)
              add_request(pick_pop(), pick_key());
            else
              add_request(pick_push(), pick_key());
        end
        6, 7: begin
          for (int i = 0; i < len; i++)
            add_request(3'($urandom_range(deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_POP_BACK)),
                        pick_key());
        end
        8:       add_request(deq_pkg::OP_CLEAR, pick_key());
        default: add_request(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pick_key());
      endcase
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || req_valid) @(negedge clk);
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_rsp_q.size() != 0)
      report_mismatch("responses never returned", expected_rsp_q.size(), '0);

    if (mismatches == 0) begin
      $display("double_ended_queue_unit verification clean");
    end else begin
      $display("double_ended_queue_unit verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("double_ended_queue_unit verification failed");
    $finish;
  end

endmodule
